// ===== src/ycbcr_hue_key_color_replace_defines.svh =====
// Assertion macros for the hue key color replace block.
`ifndef YCBCR_HUE_KEY_COLOR_REPLACE_DEFINES_SVH
`define YCBCR_HUE_KEY_COLOR_REPLACE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define YHK_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("yhk check failed");
`define YHK_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("yhk check failed");
`else
`define YHK_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define YHK_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== src/yhk_pkg.sv =====
// Types, constants and step functions of the hue key color replace block.
`timescale 1ns / 1ps
`default_nettype none
package yhk_pkg;

  localparam int CORD_STEPS = 23;
  localparam int DIV_STEPS  = 13;
  localparam int ST_A       = CORD_STEPS + 1;
  localparam int ST_B       = CORD_STEPS + 2;
  localparam int ST_C       = CORD_STEPS + 3;
  localparam int ST_OUT     = CORD_STEPS + 4;
  localparam int NST        = CORD_STEPS + 5;

  localparam logic signed [25:0] QUARTER_TURN = 26'sd4194304;

  typedef enum logic [2:0] {
    REG_KEY_Y     = 3'd0,
    REG_KEY_CB    = 3'd1,
    REG_KEY_CR    = 3'd2,
    REG_TARGET_Y  = 3'd3,
    REG_TARGET_CB = 3'd4,
    REG_TARGET_CR = 3'd5,
    REG_HUE_TOL   = 3'd6,
    REG_SAT_TOL   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [26:0] x;
    logic signed [26:0] y;
    logic signed [25:0] z;
  } vec_t;

  typedef struct packed {
    logic [12:0] rem;
    logic [12:0] q;
  } div_t;

  typedef struct packed {
    vec_t               pv;
    logic               pzero;
    vec_t               kv;
    logic               kzero;
    logic signed [15:0] y;
    logic signed [15:0] cb;
    logic signed [15:0] cr;
    logic [14:0]        py;
    logic [16:0]        mc;
    logic               tyscale;
    logic               bbig;
    div_t               tdiv;
    div_t               bdiv;
  } cord_t;

  typedef struct packed {
    logic [16:0]        h;
    logic [16:0]        sdist;
    logic signed [15:0] y;
    logic signed [15:0] cb;
    logic signed [15:0] cr;
    logic [14:0]        py;
    logic               tyscale;
    logic               bbig;
    logic [12:0]        tq;
    logic [12:0]        bq;
  } post_a_t;

  typedef struct packed {
    logic signed [21:0] w;
    logic signed [15:0] y;
    logic signed [15:0] cb;
    logic signed [15:0] cr;
    logic [14:0]        py;
    logic               tyscale;
    logic               bbig;
    logic [12:0]        tq;
    logic [12:0]        bq;
  } post_b_t;

  typedef struct packed {
    logic               wpos;
    logic signed [31:0] prcb;
    logic signed [31:0] prcr;
    logic signed [31:0] pry;
    logic signed [15:0] y;
    logic signed [15:0] cb;
    logic signed [15:0] cr;
    logic [14:0]        py;
  } post_c_t;

  // atan(2^-i) in units of pi/2^23
  function automatic logic [21:0] atan_lut(input int unsigned i);
    logic [21:0] v;
    case (i)
      0:  v = 22'd2097152;
      1:  v = 22'd1238021;
      2:  v = 22'd654136;
      3:  v = 22'd332050;
      4:  v = 22'd166669;
      5:  v = 22'd83416;
      6:  v = 22'd41718;
      7:  v = 22'd20860;
      8:  v = 22'd10430;
      9:  v = 22'd5215;
      10: v = 22'd2608;
      11: v = 22'd1304;
      12: v = 22'd652;
      13: v = 22'd326;
      14: v = 22'd163;
      15: v = 22'd81;
      16: v = 22'd41;
      17: v = 22'd20;
      18: v = 22'd10;
      19: v = 22'd5;
      20: v = 22'd3;
      21: v = 22'd1;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // scale by 256 and turn the left half plane into the right one
  function automatic vec_t prerot(input logic signed [15:0] cb,
                                  input logic signed [15:0] cr);
    vec_t               v;
    logic signed [26:0] xs;
    logic signed [26:0] ys;
    xs = {{3{cb[15]}}, cb, 8'b0};
    ys = {{3{cr[15]}}, cr, 8'b0};
    if (!xs[26]) begin
      v.x = xs;
      v.y = ys;
      v.z = '0;
    end else if (!ys[26]) begin
      v.x = ys;
      v.y = -xs;
      v.z = QUARTER_TURN;
    end else begin
      v.x = -ys;
      v.y = xs;
      v.z = -QUARTER_TURN;
    end
    return v;
  endfunction

  function automatic vec_t cordic_iter(input vec_t v, input int unsigned i);
    vec_t               r;
    logic signed [26:0] xs;
    logic signed [26:0] ys;
    logic signed [25:0] a;
    xs = v.x >>> i;
    ys = v.y >>> i;
    a  = $signed({4'b0, atan_lut(i)});
    if (!v.y[26]) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + a;
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - a;
    end
    return r;
  endfunction

  // one restoring division bit; rem stays below the divisor
  function automatic div_t div_iter(input div_t d, input logic [12:0] dv);
    div_t        r;
    logic [13:0] t;
    logic [13:0] s;
    logic        ge;
    t  = {d.rem, d.q[12]};
    s  = t - {1'b0, dv};
    ge = (t >= {1'b0, dv});
    r.rem = ge ? s[12:0] : t[12:0];
    r.q   = {d.q[11:0], ge};
    return r;
  endfunction

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] a;
    a = {v[15], v};
    return v[15] ? 17'(-a) : 17'(a);
  endfunction

  function automatic logic [12:0] abs13(input logic signed [12:0] v);
    logic signed [13:0] a;
    logic signed [13:0] n;
    a = {v[12], v};
    n = -a;
    return v[12] ? n[12:0] : a[12:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/ycbcr_hue_key_color_replace.sv =====
// Top level of the YCbCr hue key color replace pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "ycbcr_hue_key_color_replace_defines.svh"
// Hue key color replace. Each pixel word (in_y, in_cb, in_cr) runs through a
// 28-stage pipeline and comes out as one result word. One pixel enters per
// clock when the output side keeps up. The depth is set by the 23-step
// vectoring CORDIC, one iteration per stage, which finds the chroma angle of
// the pixel and, in a lane beside it, of the key color. The two 13-bit
// restoring dividers (scaled target luma and relative chroma weight) run one
// quotient bit per stage in the first 13 CORDIC stages. Four stages follow:
// angle distance, blend weight, the three products, and the final add. Every
// stage holds its own valid bit and moves when the next one is free, so
// bubbles close up and the block keeps taking words while a finished result
// waits on out_ready. Registers reset to 0; the user must write them through
// cfg_we, cfg_idx and cfg_wdata only while no word is in flight; unenforced.
module ycbcr_hue_key_color_replace (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [12:0]        cfg_wdata,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic signed [15:0] in_y,
  input  wire logic signed [15:0] in_cb,
  input  wire logic signed [15:0] in_cr,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [15:0] out_y,
  output      logic signed [15:0] out_cb,
  output      logic signed [15:0] out_cr
);

  // configuration registers
  logic [12:0]        key_y_r;
  logic signed [12:0] key_cb_r;
  logic signed [12:0] key_cr_r;
  logic [12:0]        target_y_r;
  logic signed [12:0] target_cb_r;
  logic signed [12:0] target_cr_r;
  logic [8:0]         hue_tol_r;
  logic [8:0]         sat_tol_r;
  logic [13:0]        sat_range_r;
  logic [13:0]        sat_range_nxt;
  logic [12:0]        satk;
  logic [12:0]        kcb_abs;
  logic [12:0]        kcr_abs;
  logic [21:0]        sat_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_y_r     <= '0;
      key_cb_r    <= '0;
      key_cr_r    <= '0;
      target_y_r  <= '0;
      target_cb_r <= '0;
      target_cr_r <= '0;
      hue_tol_r   <= '0;
      sat_tol_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        yhk_pkg::REG_KEY_Y:     key_y_r     <= cfg_wdata;
        yhk_pkg::REG_KEY_CB:    key_cb_r    <= cfg_wdata;
        yhk_pkg::REG_KEY_CR:    key_cr_r    <= cfg_wdata;
        yhk_pkg::REG_TARGET_Y:  target_y_r  <= cfg_wdata;
        yhk_pkg::REG_TARGET_CB: target_cb_r <= cfg_wdata;
        yhk_pkg::REG_TARGET_CR: target_cr_r <= cfg_wdata;
        yhk_pkg::REG_HUE_TOL:   hue_tol_r   <= cfg_wdata[8:0];
        yhk_pkg::REG_SAT_TOL:   sat_tol_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // key chroma magnitude, at least one
  always_comb begin
    kcb_abs = yhk_pkg::abs13(key_cb_r);
    kcr_abs = yhk_pkg::abs13(key_cr_r);
    satk    = (kcb_abs > kcr_abs) ? kcb_abs : kcr_abs;
    if (satk == '0) satk = 13'd1;
    sat_prod      = sat_tol_r * satk;
    sat_range_nxt = sat_prod[21:8];
  end

  // only read far down the pipe, so it may lag the config registers
  always_ff @(posedge clk) begin
    sat_range_r <= sat_range_nxt;
  end

  // stall chain: a stage loads when it is empty or its word moves on
  logic [yhk_pkg::NST-1:0] vld_r;
  logic [yhk_pkg::NST-1:0] vld_nxt;
  logic [yhk_pkg::NST-1:0] en;

  assign en[yhk_pkg::NST-1] = !vld_r[yhk_pkg::NST-1] || out_ready;
  for (genvar k = 0; k < yhk_pkg::NST - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[yhk_pkg::NST-1];

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < yhk_pkg::NST; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // entry stage: quarter-turn, magnitude, divider setup
  yhk_pkg::cord_t cs_r   [yhk_pkg::CORD_STEPS+1];
  yhk_pkg::cord_t cs_nxt [yhk_pkg::CORD_STEPS+1];

  logic [14:0] in_py;
  logic [16:0] in_mc;
  logic [16:0] in_acb;
  logic [16:0] in_acr;
  logic [25:0] ty_prod;
  logic        in_tyscale;
  logic        in_bbig;

  always_comb begin
    in_py      = in_y[15] ? '0 : in_y[14:0];
    in_acb     = yhk_pkg::abs16(in_cb);
    in_acr     = yhk_pkg::abs16(in_cr);
    in_mc      = (in_acb > in_acr) ? in_acb : in_acr;
    in_tyscale = (in_py < {2'b0, key_y_r});
    in_bbig    = (in_mc >= {4'b0, satk});
    ty_prod    = target_y_r * in_py[12:0];

    cs_nxt[0].pv      = yhk_pkg::prerot(in_cb, in_cr);
    cs_nxt[0].pzero   = (in_cb == '0) && (in_cr == '0);
    cs_nxt[0].kv      = yhk_pkg::prerot({{3{key_cb_r[12]}}, key_cb_r},
                                        {{3{key_cr_r[12]}}, key_cr_r});
    cs_nxt[0].kzero   = (key_cb_r == '0) && (key_cr_r == '0);
    cs_nxt[0].y       = in_y;
    cs_nxt[0].cb      = in_cb;
    cs_nxt[0].cr      = in_cr;
    cs_nxt[0].py      = in_py;
    cs_nxt[0].mc      = in_mc;
    cs_nxt[0].tyscale = in_tyscale;
    cs_nxt[0].bbig    = in_bbig;
    cs_nxt[0].tdiv.rem = ty_prod[25:13];
    cs_nxt[0].tdiv.q   = ty_prod[12:0];
    // (mc << 12) / satk as a 26-bit dividend; only used when mc < satk
    cs_nxt[0].bdiv.rem = in_bbig ? '0 : {1'b0, in_mc[12:1]};
    cs_nxt[0].bdiv.q   = in_bbig ? '0 : {in_mc[0], 12'b0};
  end

  // CORDIC stages, dividers ride along in the first DIV_STEPS of them
  for (genvar i = 0; i < yhk_pkg::CORD_STEPS; i++) begin : g_cord
    always_comb begin
      cs_nxt[i+1]    = cs_r[i];
      cs_nxt[i+1].pv = yhk_pkg::cordic_iter(cs_r[i].pv, i);
      cs_nxt[i+1].kv = yhk_pkg::cordic_iter(cs_r[i].kv, i);
      if (i < yhk_pkg::DIV_STEPS) begin
        cs_nxt[i+1].tdiv = yhk_pkg::div_iter(cs_r[i].tdiv, key_y_r);
        cs_nxt[i+1].bdiv = yhk_pkg::div_iter(cs_r[i].bdiv, satk);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= yhk_pkg::CORD_STEPS; k++) begin
      if (en[k]) cs_r[k] <= cs_nxt[k];
    end
  end

  // stage A: wrapped, rounded angle distance and chroma distance
  yhk_pkg::cord_t     cl;
  yhk_pkg::post_a_t   pa_r;
  yhk_pkg::post_a_t   pa_nxt;
  logic signed [25:0] pang;
  logic signed [25:0] kang;
  logic signed [26:0] dang;
  logic [26:0]        dmag;
  logic [26:0]        dsum;
  logic [18:0]        hmag;
  logic [15:0]        hwrap;
  logic signed [17:0] sdiff;

  always_comb begin
    cl    = cs_r[yhk_pkg::CORD_STEPS];
    pang  = cl.pzero ? '0 : cl.pv.z;
    kang  = cl.kzero ? '0 : cl.kv.z;
    dang  = {pang[25], pang} - {kang[25], kang};
    dmag  = dang[26] ? 27'(-dang) : 27'(dang);
    dsum  = dmag + 27'd128;
    hmag  = dsum[26:8];
    hwrap = dang[26] ? 16'(-hmag[15:0]) : hmag[15:0];
    sdiff = $signed({5'b0, satk}) - $signed({1'b0, cl.mc});

    pa_nxt.h       = yhk_pkg::abs16(hwrap);
    pa_nxt.sdist   = sdiff[17] ? 17'(-sdiff) : sdiff[16:0];
    pa_nxt.y       = cl.y;
    pa_nxt.cb      = cl.cb;
    pa_nxt.cr      = cl.cr;
    pa_nxt.py      = cl.py;
    pa_nxt.tyscale = cl.tyscale;
    pa_nxt.bbig    = cl.bbig;
    pa_nxt.tq      = cl.tdiv.q;
    pa_nxt.bq      = cl.bdiv.q;
  end

  always_ff @(posedge clk) begin
    if (en[yhk_pkg::ST_A]) pa_r <= pa_nxt;
  end

  // stage B: blend weight
  yhk_pkg::post_b_t   pb_r;
  yhk_pkg::post_b_t   pb_nxt;
  logic signed [17:0] hex;
  logic signed [17:0] sex;
  logic [16:0]        hpen;
  logic [16:0]        spen;

  always_comb begin
    hex  = $signed({1'b0, pa_r.h}) - $signed({2'b0, hue_tol_r, 7'b0});
    sex  = $signed({1'b0, pa_r.sdist}) - $signed({4'b0, sat_range_r});
    hpen = hex[17] ? '0 : hex[16:0];
    spen = sex[17] ? '0 : sex[16:0];

    pb_nxt.w       = 22'sd4096 - $signed({5'b0, hpen}) - $signed({2'b0, spen, 3'b0});
    pb_nxt.y       = pa_r.y;
    pb_nxt.cb      = pa_r.cb;
    pb_nxt.cr      = pa_r.cr;
    pb_nxt.py      = pa_r.py;
    pb_nxt.tyscale = pa_r.tyscale;
    pb_nxt.bbig    = pa_r.bbig;
    pb_nxt.tq      = pa_r.tq;
    pb_nxt.bq      = pa_r.bq;
  end

  always_ff @(posedge clk) begin
    if (en[yhk_pkg::ST_B]) pb_r <= pb_nxt;
  end

  // stage C: luma weight and the three blend products
  yhk_pkg::post_c_t   pc_r;
  yhk_pkg::post_c_t   pc_nxt;
  logic [12:0]        wu;
  logic [12:0]        bw;
  logic [12:0]        tyv;
  logic signed [13:0] wsg;
  logic signed [13:0] bsg;
  logic signed [17:0] dcb;
  logic signed [17:0] dcr;
  logic signed [17:0] dy;

  always_comb begin
    wu  = pb_r.w[12:0];
    bw  = (pb_r.bbig || (wu < pb_r.bq)) ? wu : pb_r.bq;
    tyv = pb_r.tyscale ? pb_r.tq : target_y_r;
    wsg = $signed({1'b0, wu});
    bsg = $signed({1'b0, bw});
    dcb = $signed({{5{target_cb_r[12]}}, target_cb_r}) - $signed({{2{pb_r.cb[15]}}, pb_r.cb});
    dcr = $signed({{5{target_cr_r[12]}}, target_cr_r}) - $signed({{2{pb_r.cr[15]}}, pb_r.cr});
    dy  = $signed({5'b0, tyv}) - $signed({3'b0, pb_r.py});

    pc_nxt.wpos = !pb_r.w[21] && (pb_r.w != '0);
    pc_nxt.prcb = 32'(dcb) * 32'(wsg);
    pc_nxt.prcr = 32'(dcr) * 32'(wsg);
    pc_nxt.pry  = 32'(dy) * 32'(bsg);
    pc_nxt.y    = pb_r.y;
    pc_nxt.cb   = pb_r.cb;
    pc_nxt.cr   = pb_r.cr;
    pc_nxt.py   = pb_r.py;
  end

  always_ff @(posedge clk) begin
    if (en[yhk_pkg::ST_C]) pc_r <= pc_nxt;
  end

  // output stage: shift down by 12 and add, or pass the pixel through
  logic signed [15:0] out_y_r;
  logic signed [15:0] out_cb_r;
  logic signed [15:0] out_cr_r;
  logic signed [15:0] out_y_nxt;
  logic signed [15:0] out_cb_nxt;
  logic signed [15:0] out_cr_nxt;

  always_comb begin
    if (pc_r.wpos) begin
      out_y_nxt  = $signed({1'b0, pc_r.py}) + pc_r.pry[27:12];
      out_cb_nxt = pc_r.cb + pc_r.prcb[27:12];
      out_cr_nxt = pc_r.cr + pc_r.prcr[27:12];
    end else begin
      out_y_nxt  = pc_r.y;
      out_cb_nxt = pc_r.cb;
      out_cr_nxt = pc_r.cr;
    end
  end

  always_ff @(posedge clk) begin
    if (en[yhk_pkg::ST_OUT]) begin
      out_y_r  <= out_y_nxt;
      out_cb_r <= out_cb_nxt;
      out_cr_r <= out_cr_nxt;
    end
  end

  assign out_y  = out_y_r;
  assign out_cb = out_cb_r;
  assign out_cr = out_cr_r;

  // luma divider remainder stays below the key luma it was divided by
  `YHK_ASSERT_NOW(a_tdiv_rem, clk, rst_n, vld_r[yhk_pkg::DIV_STEPS] && cs_r[yhk_pkg::DIV_STEPS].tyscale, cs_r[yhk_pkg::DIV_STEPS].tdiv.rem < key_y_r)
  // relative chroma quotient is below 4096 whenever it is used
  `YHK_ASSERT_NOW(a_bdiv_range, clk, rst_n, vld_r[yhk_pkg::DIV_STEPS] && !cs_r[yhk_pkg::DIV_STEPS].bbig, cs_r[yhk_pkg::DIV_STEPS].bdiv.q < 13'd4096)
  // a word with no positive weight leaves the block unchanged
  `YHK_ASSERT_NEXT(a_pass, clk, rst_n, vld_r[yhk_pkg::ST_C] && en[yhk_pkg::ST_OUT] && !pc_r.wpos, out_y == $past(pc_r.y) && out_cb == $past(pc_r.cb) && out_cr == $past(pc_r.cr))

endmodule
`default_nettype wire
